// ===== src/pcms_pkg.sv =====
package pcms_pkg;

	localparam int unsigned FIELD_W = 16;
	localparam int unsigned SUM_W   = 56;
	localparam int unsigned ACC_W   = 50;
	localparam int unsigned AMP_W   = 25;
	localparam int unsigned DEN_W   = 64;
	localparam int unsigned QUO_W   = 16;
	localparam int unsigned CNT_W   = 5;
	localparam int unsigned IDX_W   = 2;
	localparam int unsigned ROOT_STEPS = 25;

	typedef enum logic [IDX_W-1:0] {
		REG_WEIGHT_A = 2'd0,
		REG_WEIGHT_B = 2'd1,
		REG_WEIGHT_C = 2'd2,
		REG_WEIGHT_D = 2'd3
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQ,
		ST_WT,
		ST_ROOT,
		ST_PREP,
		ST_ACC,
		ST_SUM,
		ST_PDIV,
		ST_PEND,
		ST_FINIT,
		ST_FDIV,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic sq;
		logic wt;
		logic root;
		logic prep;
		logic acc;
		logic sum;
		logic div_step;
		logic pend;
		logic finit;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic last_mode;
		logic passes;
		logic fend;
		logic amp_zero;
		logic out_full;
	} sts_t;

endpackage

// ===== src/pcms_if.sv =====
interface pcms_in_if;
	import pcms_pkg::*;
	logic               valid;
	logic               ready;
	logic [FIELD_W-1:0] measured_amp;
	logic [FIELD_W-1:0] mag_mode_a;
	logic [FIELD_W-1:0] mag_mode_b;
	logic [FIELD_W-1:0] mag_mode_c;
	logic [FIELD_W-1:0] mag_dominant;
	logic               pixel_passes;
	logic               frame_end;

	modport source (output valid, measured_amp, mag_mode_a, mag_mode_b, mag_mode_c,
		mag_dominant, pixel_passes, frame_end, input ready);
	modport sink (input valid, measured_amp, mag_mode_a, mag_mode_b, mag_mode_c,
		mag_dominant, pixel_passes, frame_end, output ready);
endinterface

interface pcms_out_if;
	import pcms_pkg::*;
	logic               valid;
	logic               ready;
	logic [FIELD_W-1:0] dom_scaled;
	logic               zero_model;
	logic [FIELD_W-1:0] frame_error;
	logic               error_valid;

	modport source (output valid, dom_scaled, zero_model, frame_error, error_valid,
		input ready);
	modport sink (input valid, dom_scaled, zero_model, frame_error, error_valid,
		output ready);
endinterface

// ===== src/partial_coherence_modulus_scale.sv =====
// sequence per pixel: mode sums, root, error terms, divide and rescale, then output load; the divide
// and rescale are skipped when the pixel is masked or the model is zero, and a frame's last pixel
// adds the frame error divide
// a new pixel is accepted only in idle, after the previous result has gone to the output register
// a finished result waits in the output register while the next pixel is taken
// reset: arst_n clears the controller, the frame sums and weights (dominant weight to all ones)
module partial_coherence_modulus_scale #(
	parameter int MODE_COUNT = 4,
	parameter int MAG_BITS   = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [pcms_pkg::IDX_W-1:0]   cfg_idx,
	input  logic [pcms_pkg::FIELD_W-1:0] cfg_wdata,
	pcms_in_if.sink                      in_ch,
	pcms_out_if.source                   out_ch
);
	import pcms_pkg::*;

	cmd_t cmd;
	sts_t sts;
	logic rdy;

	// sequencer
	pcms_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (rdy),
		.sts      (sts),
		.cmd      (cmd)
	);

	assign in_ch.ready = rdy;

	// arithmetic and storage
	pcms_dp #(
		.MODE_COUNT (MODE_COUNT),
		.MAG_BITS   (MAG_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

// ===== src/pcms_ctrl.sv =====
module pcms_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  pcms_pkg::sts_t   sts,
	output pcms_pkg::cmd_t   cmd
);
	import pcms_pkg::*;

	state_t           state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;

	// state and step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_SQ;
				end
			end
			ST_SQ: begin
				cmd.sq  = 1'b1;
				state_d = ST_WT;
			end
			ST_WT: begin
				cmd.wt = 1'b1;
				if (sts.last_mode) begin
					cnt_d   = '0;
					state_d = ST_ROOT;
				end else begin
					state_d = ST_SQ;
				end
			end
			ST_ROOT: begin
				cmd.root = 1'b1;
				cnt_d    = cnt_q + 1'b1;
				if (cnt_q == CNT_W'(ROOT_STEPS - 1)) state_d = ST_PREP;
			end
			ST_PREP: begin
				cmd.prep = 1'b1;
				state_d  = ST_ACC;
			end
			ST_ACC: begin
				cmd.acc = 1'b1;
				state_d = ST_SUM;
			end
			ST_SUM: begin
				cmd.sum = 1'b1;
				cnt_d   = '0;
				if (sts.passes && !sts.amp_zero) state_d = ST_PDIV;
				else if (sts.fend)                state_d = ST_FINIT;
				else                              state_d = ST_DONE;
			end
			ST_PDIV: begin
				cmd.div_step = 1'b1;
				cnt_d        = cnt_q + 1'b1;
				if (cnt_q == CNT_W'(QUO_W - 1)) state_d = ST_PEND;
			end
			ST_PEND: begin
				cmd.pend = 1'b1;
				state_d  = sts.fend ? ST_FINIT : ST_DONE;
			end
			ST_FINIT: begin
				cmd.finit = 1'b1;
				cnt_d     = '0;
				state_d   = ST_FDIV;
			end
			ST_FDIV: begin
				cmd.div_step = 1'b1;
				cnt_d        = cnt_q + 1'b1;
				if (cnt_q == CNT_W'(QUO_W - 1)) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!sts.out_full) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// ===== src/pcms_dp.sv =====
module pcms_dp #(
	parameter int MODE_COUNT = 4,
	parameter int MAG_BITS   = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [pcms_pkg::IDX_W-1:0]   cfg_idx,
	input  logic [pcms_pkg::FIELD_W-1:0] cfg_wdata,
	pcms_in_if.sink                      in_ch,
	pcms_out_if.source                   out_ch,
	input  pcms_pkg::cmd_t               cmd,
	output pcms_pkg::sts_t               sts
);
	import pcms_pkg::*;

	localparam logic [FIELD_W-1:0] MAG_CLAMP = (MAG_BITS >= 16) ? {FIELD_W{1'b1}} :
		FIELD_W'((64'd1 << MAG_BITS) - 64'd1);

	// weight registers
	logic [FIELD_W-1:0] w_q [4];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q[0] <= '0;
			w_q[1] <= '0;
			w_q[2] <= '0;
			w_q[3] <= {FIELD_W{1'b1}};
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_idx))
				REG_WEIGHT_A: w_q[0] <= cfg_wdata;
				REG_WEIGHT_B: w_q[1] <= cfg_wdata;
				REG_WEIGHT_C: w_q[2] <= cfg_wdata;
				REG_WEIGHT_D: w_q[3] <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// latched pixel
	logic [FIELD_W-1:0] meas_q, dom_q;
	logic [FIELD_W-1:0] mag_q [4];
	logic               pass_q, fend_q;
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			meas_q   <= in_ch.measured_amp;
			mag_q[0] <= in_ch.mag_mode_a;
			mag_q[1] <= in_ch.mag_mode_b;
			mag_q[2] <= in_ch.mag_mode_c;
			mag_q[3] <= in_ch.mag_dominant;
			dom_q    <= in_ch.mag_dominant;
			pass_q   <= in_ch.pixel_passes;
			fend_q   <= in_ch.frame_end;
		end
	end

	// weighted sum of squares, one mode per SQ and WT state pair; acc_q then serves as root remainder
	logic [1:0]         mode_q;
	logic [2*FIELD_W-1:0] sq_q;
	logic [ACC_W-1:0]   acc_q, res_q, bit_q;
	logic               mode_on;
	logic [ACC_W:0]     trial;
	assign mode_on = (mode_q == 2'd3) || (32'(mode_q) < MODE_COUNT - 1);
	assign trial   = {1'b0, res_q} + {1'b0, bit_q};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= '0;
			acc_q  <= '0;
			res_q  <= '0;
			bit_q  <= ACC_W'(1) << (2 * (ROOT_STEPS - 1));
		end else if (cmd.sq) begin
			sq_q <= mag_q[mode_q] * mag_q[mode_q];
		end else if (cmd.wt) begin
			if (mode_on && pass_q) acc_q <= acc_q + ACC_W'(sq_q) * ACC_W'(w_q[mode_q]);
			mode_q <= mode_q + 1'b1;
		end else if (cmd.root) begin
			if ({1'b0, acc_q} >= trial) begin
				acc_q <= acc_q - trial[ACC_W-1:0];
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	// per-pixel products and running sums
	logic [AMP_W-1:0]     amp;
	logic [AMP_W-1:0]     target;
	logic [AMP_W-1:0]     diff_q;
	logic [2*FIELD_W-1:0] prod_q, msq_q;
	logic [2*AMP_W-1:0]   dsq_q;
	logic [SUM_W-1:0]     sum_m_q, sum_d_q;
	logic [SUM_W:0]       add_m, add_d;
	assign amp    = res_q[AMP_W-1:0];
	assign target = {1'b0, meas_q, 8'd0};
	assign add_m  = {1'b0, sum_m_q} + (SUM_W+1)'(msq_q);
	assign add_d  = {1'b0, sum_d_q} + (SUM_W+1)'(dsq_q);

	always_ff @(posedge clk) begin
		if (cmd.prep) begin
			prod_q <= dom_q * meas_q;
			msq_q  <= meas_q * meas_q;
			diff_q <= (target >= amp) ? target - amp : amp - target;
		end
		if (cmd.acc) dsq_q <= diff_q * diff_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_m_q <= '0;
			sum_d_q <= '0;
		end else if (cmd.sum && pass_q) begin
			sum_m_q <= add_m[SUM_W] ? {SUM_W{1'b1}} : add_m[SUM_W-1:0];
			sum_d_q <= add_d[SUM_W] ? {SUM_W{1'b1}} : add_d[SUM_W-1:0];
		end else if (cmd.finit) begin
			sum_m_q <= '0;
			sum_d_q <= '0;
		end
	end

	// shared restoring divider, one quotient bit a cycle
	logic [DEN_W-1:0] den_q;
	logic [DEN_W:0]   rem_q, shf;
	logic [QUO_W-1:0] nlo_q, quo_q;
	logic             dsat_q, fzero_q;
	logic [SUM_W-1:0] div_num;
	logic [DEN_W-1:0] div_den;
	logic             div_init;
	assign div_init = cmd.sum || cmd.finit;
	assign div_num  = cmd.finit ? sum_d_q : {16'd0, prod_q, 8'd0};
	assign div_den  = cmd.finit ? {sum_m_q, 8'd0} : DEN_W'(amp);
	assign shf      = {rem_q[DEN_W-1:0], nlo_q[QUO_W-1]};

	always_ff @(posedge clk) begin
		if (div_init) begin
			den_q  <= div_den;
			rem_q  <= (DEN_W+1)'(div_num[SUM_W-1:QUO_W]);
			nlo_q  <= div_num[QUO_W-1:0];
			quo_q  <= '0;
			dsat_q <= {24'd0, div_num} >= {div_den, 16'd0};
		end else if (cmd.div_step) begin
			if (shf >= {1'b0, den_q}) begin
				rem_q <= shf - {1'b0, den_q};
				quo_q <= {quo_q[QUO_W-2:0], 1'b1};
			end else begin
				rem_q <= shf;
				quo_q <= {quo_q[QUO_W-2:0], 1'b0};
			end
			nlo_q <= nlo_q << 1;
		end
		if (cmd.finit) fzero_q <= (sum_m_q == '0) && (sum_d_q == '0);
	end

	// pixel result
	logic [FIELD_W-1:0] scaled_q, quo_sat;
	logic               zero_q;
	assign quo_sat = dsat_q ? {FIELD_W{1'b1}} : quo_q;
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			scaled_q <= in_ch.mag_dominant;
			zero_q   <= 1'b0;
		end else if (cmd.sum && pass_q && amp == '0) begin
			scaled_q <= {FIELD_W{1'b1}};
			zero_q   <= 1'b1;
		end else if (cmd.pend) begin
			scaled_q <= (quo_sat > MAG_CLAMP) ? MAG_CLAMP : quo_sat;
		end
	end

	// output register
	logic out_v_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_v_q <= 1'b0;
		else if (cmd.out_load) out_v_q <= 1'b1;
		else if (out_ch.ready) out_v_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_ch.dom_scaled  <= scaled_q;
			out_ch.zero_model  <= zero_q;
			out_ch.error_valid <= fend_q;
			out_ch.frame_error <= (fend_q && !fzero_q) ? quo_sat : '0;
		end
	end

	assign out_ch.valid = out_v_q;

	// status to controller
	assign sts.last_mode = (mode_q == 2'd3);
	assign sts.passes    = pass_q;
	assign sts.fend      = fend_q;
	assign sts.amp_zero  = (amp == '0);
	assign sts.out_full  = out_v_q && !out_ch.ready;

endmodule
